/* rtl/core/ptest_pkg.sv */
// shared types and constants for the 64-bit primality tester
// no dependencies

package ptest_pkg;

   localparam int unsigned WordWidth    = 64;
   localparam int unsigned SmallCount   = 12;
   localparam int unsigned WitnessCount = 7;
   localparam int unsigned SmallIdxW    = 4;
   localparam int unsigned WitIdxW      = 3;
   localparam int unsigned BitIdxW      = 6;
   localparam int unsigned ResW         = 6;
   localparam int unsigned NibIdxW      = 4;

   typedef logic [WordWidth-1:0] word_type;
   typedef logic [ResW-1:0]      res_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SMALL,
      ST_SPLIT,
      ST_BASE,
      ST_POW_STEP,
      ST_POW_WAIT,
      ST_CHECK,
      ST_SQ_WAIT,
      ST_DONE
   } seq_state_type;

   typedef enum logic [1:0] {
      MM_IDLE,
      MM_RUN,
      MM_DONE
   } mm_state_type;

   function automatic word_type small_prime(input logic [SmallIdxW-1:0] idx);
      word_type p;
      begin
         unique case (idx)
            4'd0:  p = 64'd2;
            4'd1:  p = 64'd3;
            4'd2:  p = 64'd5;
            4'd3:  p = 64'd7;
            4'd4:  p = 64'd11;
            4'd5:  p = 64'd13;
            4'd6:  p = 64'd17;
            4'd7:  p = 64'd19;
            4'd8:  p = 64'd23;
            4'd9:  p = 64'd29;
            4'd10: p = 64'd31;
            4'd11: p = 64'd37;
            default: p = 64'd37;
         endcase
         return p;
      end
   endfunction

   function automatic word_type witness_base(input logic [WitIdxW-1:0] idx);
      word_type b;
      begin
         unique case (idx)
            3'd0: b = 64'd2;
            3'd1: b = 64'd325;
            3'd2: b = 64'd9375;
            3'd3: b = 64'd28178;
            3'd4: b = 64'd450775;
            3'd5: b = 64'd9780504;
            3'd6: b = 64'd1795265022;
            default: b = 64'd2;
         endcase
         return b;
      end
   endfunction

endpackage

/* rtl/core/primality_test_64bit.sv */
// top level of the 64-bit primality tester: sequencer around shared units
// depends on ptest_pkg, ptest_modmul, ptest_modred
//
// usage: one candidate enters on the req_ stream, one is_prime item leaves
// on the rsp_ stream. req_tready is high only while the block is idle; a
// candidate is then worked on alone until its answer is taken, and the next
// candidate can be taken the cycle after.
// steps: trial division uses the residue unit once per small prime (up
// to 12). numbers past that need d and s, then for each of 7 bases one
// reduction on the multiplier plus one modular product per set exponent
// bit and one squaring per exponent bit, then the squarings of the check
// loop, at most 128 products per base. the bit-serial modular multiplier
// sets the run time.
// reset clears the sequencer and the output valid; no memories to clear.
// while rsp_tready is low the result stays in the output register and no
// new candidate is taken.

module primality_test_64bit
   import ptest_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // candidate[63:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // is_prime[0], zeros[7:1]
);

   seq_state_type        state_ff, state_in;
   word_type             n_ff, n_in;
   word_type             d_ff, d_in;
   logic [BitIdxW-1:0]   s_ff, s_in;
   logic [BitIdxW-1:0]   i_ff, i_in;
   word_type             x_ff, x_in;
   word_type             base_ff, base_in;
   word_type             e_ff, e_in;
   logic [SmallIdxW-1:0] sp_ff, sp_in;
   logic [WitIdxW-1:0]   wi_ff, wi_in;
   logic                 sq_ff, sq_in;
   logic                 go_ff, go_in;
   logic                 res_ff, res_in;
   logic                 valid_ff, valid_in;

   logic     mm_start, mr_start, mm_done, mr_done;
   word_type mm_a, mm_b, mm_p, nm1;
   res_type  mr_r;

   assign nm1 = n_ff - 64'd1;

   ptest_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .op_a    (mm_a),
      .op_b    (mm_b),
      .modulus (n_ff),
      .done    (mm_done),
      .product (mm_p)
   );

   ptest_modred u_modred (
      .clock     (clock),
      .reset     (reset),
      .start     (mr_start),
      .dividend  (n_ff),
      .prime_sel (sp_ff),
      .done      (mr_done),
      .remainder (mr_r)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         go_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         go_ff    <= go_in;
      end
      n_ff    <= n_in;
      d_ff    <= d_in;
      s_ff    <= s_in;
      i_ff    <= i_in;
      x_ff    <= x_in;
      base_ff <= base_in;
      e_ff    <= e_in;
      sp_ff   <= sp_in;
      wi_ff   <= wi_in;
      sq_ff   <= sq_in;
      res_ff  <= res_in;
   end

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      d_in     = d_ff;
      s_in     = s_ff;
      i_in     = i_ff;
      x_in     = x_ff;
      base_in  = base_ff;
      e_in     = e_ff;
      sp_in    = sp_ff;
      wi_in    = wi_ff;
      sq_in    = sq_ff;
      go_in    = 1'b0;
      res_in   = res_ff;
      valid_in = valid_ff;
      mm_start = 1'b0;
      mr_start = 1'b0;
      mm_a     = x_ff;
      mm_b     = x_ff;
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && !valid_ff) begin
               n_in  = req_tdata;
               sp_in = '0;
               if (req_tdata < 64'd2) begin
                  res_in   = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  go_in    = 1'b1;
                  state_in = ST_SMALL;
               end
            end
         end
         ST_SMALL: begin
            mr_start = go_ff;
            if (mr_done) begin
               if (mr_r == '0) begin
                  res_in   = (n_ff == small_prime(sp_ff));
                  state_in = ST_DONE;
               end else if (sp_ff == SmallIdxW'(SmallCount - 1)) begin
                  d_in     = nm1;
                  s_in     = '0;
                  state_in = ST_SPLIT;
               end else begin
                  sp_in = sp_ff + 1'b1;
                  go_in = 1'b1;
               end
            end
         end
         ST_SPLIT: begin
            if (d_ff[0]) begin
               wi_in    = '0;
               go_in    = 1'b1;
               state_in = ST_BASE;
            end else begin
               d_in = {1'b0, d_ff[WordWidth-1:1]};
               s_in = s_ff + 1'b1;
            end
         end
         ST_BASE: begin
            // base mod n as the product 1 * base on the multiplier
            mm_start = go_ff;
            mm_a     = 64'd1;
            mm_b     = witness_base(wi_ff);
            if (mm_done) begin
               if (mm_p == '0) begin
                  if (wi_ff == WitIdxW'(WitnessCount - 1)) begin
                     res_in   = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     wi_in = wi_ff + 1'b1;
                     go_in = 1'b1;
                  end
               end else begin
                  base_in  = mm_p;
                  x_in     = 64'd1;
                  e_in     = d_ff;
                  sq_in    = 1'b0;
                  state_in = ST_POW_STEP;
               end
            end
         end
         ST_POW_STEP: begin
            // alternate: multiply if exponent bit set, then square base
            if (e_ff == '0) begin
               i_in     = 6'd1;
               state_in = ST_CHECK;
            end else begin
               mm_start = 1'b1;
               if (!sq_ff && e_ff[0]) begin
                  mm_a = x_ff;
                  mm_b = base_ff;
               end else begin
                  mm_a  = base_ff;
                  mm_b  = base_ff;
                  sq_in = 1'b1;
               end
               state_in = ST_POW_WAIT;
            end
         end
         ST_POW_WAIT: begin
            if (mm_done) begin
               if (sq_ff) begin
                  base_in = mm_p;
                  e_in    = {1'b0, e_ff[WordWidth-1:1]};
                  sq_in   = 1'b0;
               end else begin
                  x_in  = mm_p;
                  sq_in = 1'b1;
               end
               state_in = ST_POW_STEP;
            end
         end
         ST_CHECK: begin
            if ((i_ff == 6'd1 && x_ff == 64'd1) || x_ff == nm1) begin
               if (wi_ff == WitIdxW'(WitnessCount - 1)) begin
                  res_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  wi_in    = wi_ff + 1'b1;
                  go_in    = 1'b1;
                  state_in = ST_BASE;
               end
            end else if (i_ff >= s_ff) begin
               res_in   = 1'b0;
               state_in = ST_DONE;
            end else begin
               mm_start = 1'b1;
               mm_a     = x_ff;
               mm_b     = x_ff;
               state_in = ST_SQ_WAIT;
            end
         end
         ST_SQ_WAIT: begin
            if (mm_done) begin
               x_in     = mm_p;
               i_in     = i_ff + 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_DONE: begin
            if (!valid_ff) begin
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE) && !valid_ff;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'd0, res_ff};

endmodule

/* rtl/core/ptest_modmul.sv */
// shared modular multiplier: (a*b) mod m by shift-and-add, one bit of b per cycle
// depends on ptest_pkg

module ptest_modmul
   import ptest_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  word_type op_a,
   input  word_type op_b,
   input  word_type modulus,
   output logic     done,
   output word_type product
);

   mm_state_type          state_ff, state_in;
   word_type              acc_ff, acc_in;
   word_type              a_ff, a_in;
   word_type              b_ff, b_in;
   word_type              m_ff, m_in;
   logic [BitIdxW-1:0]    cnt_ff, cnt_in;

   logic [WordWidth:0]    dbl_sum;
   word_type              dbl_val;
   logic [WordWidth:0]    add_sum;
   word_type              add_val;

   always_comb begin
      dbl_sum = {1'b0, acc_ff} + {1'b0, acc_ff};
      if (dbl_sum[WordWidth] || dbl_sum[WordWidth-1:0] >= m_ff) begin
         dbl_val = dbl_sum[WordWidth-1:0] - m_ff;
      end else begin
         dbl_val = dbl_sum[WordWidth-1:0];
      end
      add_sum = {1'b0, dbl_val} + {1'b0, a_ff};
      if (add_sum[WordWidth] || add_sum[WordWidth-1:0] >= m_ff) begin
         add_val = add_sum[WordWidth-1:0] - m_ff;
      end else begin
         add_val = add_sum[WordWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MM_IDLE;
      end else begin
         state_ff <= state_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      m_ff   <= m_in;
      cnt_ff <= cnt_in;
   end

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      m_in     = m_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         MM_IDLE, MM_DONE: begin
            state_in = MM_IDLE;
            if (start) begin
               acc_in   = '0;
               a_in     = op_a;
               b_in     = op_b;
               m_in     = modulus;
               cnt_in   = '1;
               state_in = MM_RUN;
            end
         end
         MM_RUN: begin
            acc_in = b_ff[WordWidth-1] ? add_val : dbl_val;
            b_in   = {b_ff[WordWidth-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = MM_DONE;
            end
         end
         default: state_in = MM_IDLE;
      endcase
   end

   assign done    = (state_ff == MM_DONE);
   assign product = acc_ff;

endmodule

/* rtl/core/ptest_modred.sv */
// residue unit: 64-bit word mod one small trial prime, one nibble per cycle
// depends on ptest_pkg

module ptest_modred
   import ptest_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  word_type             dividend,
   input  logic [SmallIdxW-1:0] prime_sel,
   output logic                 done,
   output res_type              remainder
);

   mm_state_type          state_ff, state_in;
   res_type               rem_ff, rem_in;
   word_type              x_ff, x_in;
   res_type               p_ff, p_in;
   logic [NibIdxW-1:0]    cnt_ff, cnt_in;

   word_type              p_word;
   logic [ResW+3:0]       v8, v4, v2, v1, v0;
   res_type               red;

   assign p_word = small_prime(prime_sel);

   // remainder stays below p, so 16*rem + nibble < 16p
   always_comb begin
      v8 = {rem_ff, x_ff[WordWidth-1 -: 4]};
      if (v8 >= {1'b0, p_ff, 3'b000}) begin
         v4 = v8 - {1'b0, p_ff, 3'b000};
      end else begin
         v4 = v8;
      end
      if (v4 >= {2'b00, p_ff, 2'b00}) begin
         v2 = v4 - {2'b00, p_ff, 2'b00};
      end else begin
         v2 = v4;
      end
      if (v2 >= {3'b000, p_ff, 1'b0}) begin
         v1 = v2 - {3'b000, p_ff, 1'b0};
      end else begin
         v1 = v2;
      end
      if (v1 >= {4'b0000, p_ff}) begin
         v0 = v1 - {4'b0000, p_ff};
      end else begin
         v0 = v1;
      end
      red = v0[ResW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MM_IDLE;
      end else begin
         state_ff <= state_in;
      end
      rem_ff <= rem_in;
      x_ff   <= x_in;
      p_ff   <= p_in;
      cnt_ff <= cnt_in;
   end

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      x_in     = x_ff;
      p_in     = p_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         MM_IDLE, MM_DONE: begin
            state_in = MM_IDLE;
            if (start) begin
               rem_in   = '0;
               x_in     = dividend;
               p_in     = p_word[ResW-1:0];
               cnt_in   = '1;
               state_in = MM_RUN;
            end
         end
         MM_RUN: begin
            rem_in = red;
            x_in   = {x_ff[WordWidth-5:0], 4'b0000};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = MM_DONE;
            end
         end
         default: state_in = MM_IDLE;
      endcase
   end

   assign done      = (state_ff == MM_DONE);
   assign remainder = rem_ff;

endmodule
